// ----- hw/rtl/ttc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttc_pkg
// Shared types and constants of the triangle tangent calculator.
// ----------------------------------------------------------------------------
package ttc_pkg;

  localparam int unsigned CW = 32;  // coordinate width, Q16.16
  localparam int unsigned DW = 33;  // edge / uv delta width, Q17.16
  localparam int unsigned PW = 66;  // product width
  localparam int unsigned AW = 67;  // difference of products, Q32

  // |det| at or below this many Q32 LSB is degenerate
  localparam logic [AW-1:0] DET_EPS = 67'd429496;

  localparam logic [4:0] SD_SQRT_LAST = 5'd31;  // 32 root steps
  localparam logic [4:0] SD_DIV_LAST  = 5'd30;  // 31 quotient bits

  typedef struct packed {
    logic start;
    logic div;
  } sd_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } sd_rsp_t;

endpackage

// ----- hw/rtl/ttc_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttc_if
// Vertex and tangent word channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface ttc_vtx_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [31:0] tex_u;
  logic signed [31:0] tex_v;
  logic               last_vertex;

  modport source (output valid, pos_x, pos_y, pos_z, tex_u, tex_v, last_vertex,
                  input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, tex_u, tex_v, last_vertex,
                output ready);
endinterface

interface ttc_tan_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] tangent_x;
  logic signed [31:0] tangent_y;
  logic signed [31:0] tangent_z;
  logic               degenerate_uv;

  modport source (output valid, tangent_x, tangent_y, tangent_z, degenerate_uv,
                  input ready);
  modport sink (input valid, tangent_x, tangent_y, tangent_z, degenerate_uv,
                output ready);
endinterface

// ----- hw/rtl/ttc_mul.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttc_mul
// Shared signed 33x33 multiplier with registered product.
// ----------------------------------------------------------------------------
module ttc_mul (
  input  logic                            clk_i,
  input  logic signed [ttc_pkg::DW-1:0]   a_i,
  input  logic signed [ttc_pkg::DW-1:0]   b_i,
  output logic signed [ttc_pkg::PW-1:0]   p_o
);

  logic signed [ttc_pkg::PW-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

// ----- hw/rtl/ttc_sqdiv.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttc_sqdiv
// Bit-serial integer square root (64-bit radicand) and restoring divider
// (62-bit numerator, 32-bit divisor, 31-bit quotient), one step per cycle.
// ----------------------------------------------------------------------------
module ttc_sqdiv (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ttc_pkg::sd_req_t    req_i,
  input  logic [63:0]         rad_i,
  input  logic [61:0]         num_i,
  input  logic [31:0]         den_i,
  output logic [31:0]         res_o,
  output ttc_pkg::sd_rsp_t    rsp_o
);

  logic        busy_q, done_q, mode_q;
  logic [4:0]  cnt_q;
  logic [63:0] s_q, root_q, bit_q;
  logic [33:0] rem_q;
  logic [30:0] nlo_q, quo_q;
  logic [31:0] den_q;

  logic [64:0] trial_sum;
  logic        root_take;
  logic [33:0] trial_rem;
  logic        div_take;

  assign trial_sum = {1'b0, root_q} + {1'b0, bit_q};
  assign root_take = {1'b0, s_q} >= trial_sum;
  assign trial_rem = {rem_q[32:0], nlo_q[30]};
  assign div_take  = trial_rem >= {2'b00, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (busy_q) begin
        if (cnt_q == 5'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 5'd1;
        end
      end else if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.div ? ttc_pkg::SD_DIV_LAST : ttc_pkg::SD_SQRT_LAST;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!busy_q && req_i.start) begin
      mode_q <= req_i.div;
      s_q    <= rad_i;
      root_q <= '0;
      bit_q  <= 64'h4000_0000_0000_0000;
      rem_q  <= {3'b000, num_i[61:31]};
      nlo_q  <= num_i[30:0];
      quo_q  <= '0;
      den_q  <= den_i;
    end else if (busy_q) begin
      if (mode_q) begin
        rem_q <= div_take ? trial_rem - {2'b00, den_q} : trial_rem;
        nlo_q <= {nlo_q[29:0], 1'b0};
        quo_q <= {quo_q[29:0], div_take};
      end else begin
        if (root_take) begin
          s_q    <= s_q - trial_sum[63:0];
          root_q <= (root_q >> 1) + bit_q;
        end else begin
          root_q <= root_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
    end
  end

  assign res_o      = mode_q ? {1'b0, quo_q} : root_q[31:0];
  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;

endmodule

// ----- hw/rtl/triangle_tangent_calculator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_tangent_calculator
// Per-triangle unit tangent from a vertex word stream.
// ----------------------------------------------------------------------------
// Usage:
//   vtx_i takes one vertex word (Q16.16 position and uv, last_vertex mark).
//   Every third vertex closes a triangle and yields one tangent word on
//   tan_o (Q2.30 unit vector plus the degenerate-uv flag). A word with
//   last_vertex set ends the mesh: held corners of an open triangle drop.
//   The first two corners are taken one per cycle. The closing vertex starts
//   a run through one shared 33x33 multiplier (edge products and
//   squares), a one-bit-per-step normalize shifter, then one bit-serial
//   unit for the root (32 steps) and three divides (31 steps each).
//   After the closing vertex, vtx_i.ready stays low until the tangent word
//   is loaded, through the serial unit (skipped for a zero tangent), the
//   normalize shifts and any wait for a previous tangent word.
//   The result sits in an output register: the next triangle's corners are
//   accepted while tan_o stalls, and the sequencer only waits at the end if
//   the previous tangent word was not yet taken.
//   Reset clears the corner count and the sequencer; no word is pending.
// ----------------------------------------------------------------------------
module triangle_tangent_calculator (
  input  logic           clk_i,
  input  logic           rst_ni,
  ttc_vtx_if.sink        vtx_i,
  ttc_tan_if.source      tan_o
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_MUL   = 4'd1;
  localparam logic [3:0] ST_ABS   = 4'd2;
  localparam logic [3:0] ST_NORM  = 4'd3;
  localparam logic [3:0] ST_SQ    = 4'd4;
  localparam logic [3:0] ST_SQRTS = 4'd5;
  localparam logic [3:0] ST_SQRT  = 4'd6;
  localparam logic [3:0] ST_DIVS  = 4'd7;
  localparam logic [3:0] ST_DIV   = 4'd8;
  localparam logic [3:0] ST_FIN   = 4'd9;

  localparam int unsigned DW = ttc_pkg::DW;
  localparam int unsigned AW = ttc_pkg::AW;

  logic [3:0] state_q, state_d;
  logic [3:0] cnt_q;
  logic [1:0] idx_q;
  logic [1:0] corner_q;
  logic       ov_q;

  logic signed [31:0] p0_q [3];
  logic signed [31:0] p1_q [3];
  logic signed [31:0] u0_q, v0_q, u1_q, v1_q;

  logic signed [DW-1:0] s1_q, t1_q, s2_q, t2_q;
  logic signed [DW-1:0] pe_q [3];
  logic signed [DW-1:0] qe_q [3];

  logic signed [AW-1:0] e_q, det_q;
  logic signed [AW-1:0] t_q [3];
  logic [AW-1:0]        mag_q [3];
  logic [2:0]           neg_q;
  logic                 degen_q;
  logic [30:0]          c_q [3];
  logic [63:0]          sum_q;
  logic [31:0]          r_q;
  logic [30:0]          q_q [3];

  logic signed [31:0] tx_q, ty_q, tz_q;
  logic               dg_q;

  logic                          acc;
  logic signed [DW-1:0]          ma, mb;
  logic signed [ttc_pkg::PW-1:0] prod;
  logic signed [AW-1:0]          prod_x, diff;
  logic [AW-1:0]                 mag_or;
  logic [AW-1:0]                 dmag;
  logic                          degen;
  ttc_pkg::sd_req_t              sd_req;
  ttc_pkg::sd_rsp_t              sd_rsp;
  logic [31:0]                   sd_res;
  logic [61:0]                   sd_num;
  logic                          fin_load;

  assign vtx_i.ready = (state_q == ST_IDLE);
  assign acc         = vtx_i.valid && vtx_i.ready;

  // shared multiplier operand select
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (state_q)
      ST_MUL: begin
        unique case (cnt_q)
          4'd0:    begin ma = s1_q; mb = t2_q;    end
          4'd1:    begin ma = s2_q; mb = t1_q;    end
          4'd2:    begin ma = t2_q; mb = pe_q[0]; end
          4'd3:    begin ma = t1_q; mb = qe_q[0]; end
          4'd4:    begin ma = t2_q; mb = pe_q[1]; end
          4'd5:    begin ma = t1_q; mb = qe_q[1]; end
          4'd6:    begin ma = t2_q; mb = pe_q[2]; end
          4'd7:    begin ma = t1_q; mb = qe_q[2]; end
          default: begin ma = '0;   mb = '0;      end
        endcase
      end
      ST_SQ: begin
        unique case (cnt_q)
          4'd0:    begin ma = {2'b00, c_q[0]}; mb = {2'b00, c_q[0]}; end
          4'd1:    begin ma = {2'b00, c_q[1]}; mb = {2'b00, c_q[1]}; end
          4'd2:    begin ma = {2'b00, c_q[2]}; mb = {2'b00, c_q[2]}; end
          default: begin ma = '0; mb = '0; end
        endcase
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  ttc_mul u_mul (
    .clk_i (clk_i),
    .a_i   (ma),
    .b_i   (mb),
    .p_o   (prod)
  );

  assign prod_x = {prod[ttc_pkg::PW-1], prod};
  assign diff   = e_q - prod_x;
  assign mag_or = mag_q[0] | mag_q[1] | mag_q[2];
  assign dmag   = det_q[AW-1] ? AW'(-det_q) : AW'(det_q);
  assign degen  = dmag <= ttc_pkg::DET_EPS;

  assign sd_req.start = (state_q == ST_SQRTS) || (state_q == ST_DIVS);
  assign sd_req.div   = (state_q == ST_DIVS);
  assign sd_num       = {1'b0, c_q[idx_q], 30'b0} + {31'b0, r_q[31:1]};

  ttc_sqdiv u_sqdiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (sd_req),
    .rad_i  (sum_q),
    .num_i  (sd_num),
    .den_i  (r_q),
    .res_o  (sd_res),
    .rsp_o  (sd_rsp)
  );

  assign fin_load = (state_q == ST_FIN) && (!ov_q || tan_o.ready);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (acc && corner_q == 2'd2) state_d = ST_MUL;
      ST_MUL:   if (cnt_q == 4'd8) state_d = ST_ABS;
      ST_ABS:   state_d = ST_NORM;
      ST_NORM: begin
        if (mag_or == '0) begin
          state_d = ST_FIN;
        end else if (mag_or[AW-1:31] == '0 && mag_or[30]) begin
          state_d = ST_SQ;
        end
      end
      ST_SQ:    if (cnt_q == 4'd3) state_d = ST_SQRTS;
      ST_SQRTS: state_d = ST_SQRT;
      ST_SQRT:  if (sd_rsp.done) state_d = ST_DIVS;
      ST_DIVS:  state_d = ST_DIV;
      ST_DIV:   if (sd_rsp.done) state_d = (idx_q == 2'd2) ? ST_FIN : ST_DIVS;
      ST_FIN:   if (fin_load) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      idx_q    <= '0;
      corner_q <= '0;
      ov_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q != state_d) begin
        cnt_q <= '0;
      end else begin
        cnt_q <= cnt_q + 4'd1;
      end
      if (acc) begin
        if (corner_q == 2'd2 || vtx_i.last_vertex) begin
          corner_q <= '0;
        end else begin
          corner_q <= corner_q + 2'd1;
        end
      end
      if (state_q == ST_SQRT) begin
        idx_q <= '0;
      end else if (state_q == ST_DIV && sd_rsp.done) begin
        idx_q <= idx_q + 2'd1;
      end
      if (fin_load) begin
        ov_q <= 1'b1;
      end else if (ov_q && tan_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      if (corner_q == 2'd0) begin
        p0_q[0] <= vtx_i.pos_x;
        p0_q[1] <= vtx_i.pos_y;
        p0_q[2] <= vtx_i.pos_z;
        u0_q    <= vtx_i.tex_u;
        v0_q    <= vtx_i.tex_v;
      end else if (corner_q == 2'd1) begin
        p1_q[0] <= vtx_i.pos_x;
        p1_q[1] <= vtx_i.pos_y;
        p1_q[2] <= vtx_i.pos_z;
        u1_q    <= vtx_i.tex_u;
        v1_q    <= vtx_i.tex_v;
      end else begin
        s1_q    <= {u1_q[31], u1_q} - {u0_q[31], u0_q};
        t1_q    <= {v1_q[31], v1_q} - {v0_q[31], v0_q};
        s2_q    <= {vtx_i.tex_u[31], vtx_i.tex_u} - {u0_q[31], u0_q};
        t2_q    <= {vtx_i.tex_v[31], vtx_i.tex_v} - {v0_q[31], v0_q};
        pe_q[0] <= {p1_q[0][31], p1_q[0]} - {p0_q[0][31], p0_q[0]};
        pe_q[1] <= {p1_q[1][31], p1_q[1]} - {p0_q[1][31], p0_q[1]};
        pe_q[2] <= {p1_q[2][31], p1_q[2]} - {p0_q[2][31], p0_q[2]};
        qe_q[0] <= {vtx_i.pos_x[31], vtx_i.pos_x} - {p0_q[0][31], p0_q[0]};
        qe_q[1] <= {vtx_i.pos_y[31], vtx_i.pos_y} - {p0_q[1][31], p0_q[1]};
        qe_q[2] <= {vtx_i.pos_z[31], vtx_i.pos_z} - {p0_q[2][31], p0_q[2]};
      end
    end

    if (state_q == ST_MUL) begin
      unique case (cnt_q)
        4'd1, 4'd3, 4'd5, 4'd7: e_q    <= prod_x;
        4'd2:                   det_q  <= diff;
        4'd4:                   t_q[0] <= diff;
        4'd6:                   t_q[1] <= diff;
        4'd8:                   t_q[2] <= diff;
        default:                e_q    <= e_q;
      endcase
    end

    if (state_q == ST_ABS) begin
      degen_q <= degen;
      for (int i = 0; i < 3; i++) begin
        mag_q[i] <= t_q[i][AW-1] ? AW'(-t_q[i]) : AW'(t_q[i]);
        neg_q[i] <= t_q[i][AW-1] ^ (!degen && det_q[AW-1]);
      end
    end

    if (state_q == ST_NORM) begin
      sum_q <= '0;
      if (mag_or == '0) begin
        for (int i = 0; i < 3; i++) q_q[i] <= '0;
      end else if (mag_or[AW-1:31] != '0) begin
        for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] >> 1;
      end else if (!mag_or[30]) begin
        for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] << 1;
      end else begin
        for (int i = 0; i < 3; i++) c_q[i] <= mag_q[i][30:0];
      end
    end

    if (state_q == ST_SQ && cnt_q != 4'd0) begin
      sum_q <= sum_q + prod[63:0];
    end

    if (state_q == ST_SQRT && sd_rsp.done) begin
      r_q <= sd_res;
    end

    if (state_q == ST_DIV && sd_rsp.done) begin
      q_q[idx_q] <= sd_res[30:0];
    end

    if (fin_load) begin
      tx_q <= neg_q[0] ? -$signed({1'b0, q_q[0]}) : $signed({1'b0, q_q[0]});
      ty_q <= neg_q[1] ? -$signed({1'b0, q_q[1]}) : $signed({1'b0, q_q[1]});
      tz_q <= neg_q[2] ? -$signed({1'b0, q_q[2]}) : $signed({1'b0, q_q[2]});
      dg_q <= degen_q;
    end
  end

  assign tan_o.valid         = ov_q;
  assign tan_o.tangent_x     = tx_q;
  assign tan_o.tangent_y     = ty_q;
  assign tan_o.tangent_z     = tz_q;
  assign tan_o.degenerate_uv = dg_q;

endmodule

// ----- hw/rtl/ttc_chk.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttc_chk
// Port-level checks of the tangent calculator, bound to the top level.
// ----------------------------------------------------------------------------
module ttc_chk (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic signed [31:0] tx_i,
  input logic signed [31:0] ty_i,
  input logic signed [31:0] tz_i
);

  localparam logic signed [31:0] ONE  = 32'sd1073741824;
  localparam logic signed [31:0] HALF = 32'sd536870912;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("tangent word dropped while stalled");

  a_unit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (tx_i <= ONE) && (tx_i >= -ONE) && (ty_i <= ONE) &&
                    (ty_i >= -ONE) && (tz_i <= ONE) && (tz_i >= -ONE))
    else $error("tangent component outside unit range");

  a_unit_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (tx_i != 0 || ty_i != 0 || tz_i != 0) |->
      (tx_i >= HALF) || (tx_i <= -HALF) || (ty_i >= HALF) ||
      (ty_i <= -HALF) || (tz_i >= HALF) || (tz_i <= -HALF))
    else $error("nonzero tangent not normalized");

  a_busy_before: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("tangent word appeared without a busy phase");

endmodule

bind triangle_tangent_calculator ttc_chk u_ttc_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (vtx_i.ready),
  .out_valid_i (tan_o.valid),
  .out_ready_i (tan_o.ready),
  .tx_i        (tan_o.tangent_x),
  .ty_i        (tan_o.tangent_y),
  .tz_i        (tan_o.tangent_z)
);
